>>> hw/rtl/sdfo_pkg.sv
// Shared types for the order-preserving duplicate removal unit.
`timescale 1ns / 1ps
package sdfo_pkg;

	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
	} sdfo_in_t;

	typedef struct packed {
		logic signed [31:0] value_out;
		logic               keep;
		logic [6:0]         distinct_count;
		logic               overflow;
		logic               last_out;
	} sdfo_out_t;

	typedef struct packed {
		logic               vld;
		logic               last;
		logic               found;
		logic               kept;
		logic signed [31:0] value;
	} sdfo_tok_t;

	localparam int unsigned OUT_CNT_W = 7;

endpackage

>>> hw/rtl/stream_dedup_first_occurrence_unit.sv
// Top level of the order-preserving duplicate removal unit built as a chain of cells.
// A result passes through the register of every cell in turn and then into the output register.
// While no stall holds the chain, it takes one request per cycle and each request steps through one cell per cycle.
// The whole chain advances together and holds while a result waits under stall.
// Reset empties every cell and the pipeline; stored values themselves are not cleared.
`timescale 1ns / 1ps
module stream_dedup_first_occurrence_unit
	import sdfo_pkg::*;
#(
	parameter int unsigned DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  sdfo_in_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output sdfo_out_t result
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	sdfo_tok_t        tok [DEPTH+1];
	logic [CNT_W-1:0] cnt [DEPTH+1];
	logic             adv;
	logic             res_vld_q;
	sdfo_out_t        res_q;
	logic [CNT_W+OUT_CNT_W-1:0] cnt_ext;

	assign adv        = !res_vld_q || !result_stall;
	assign item_stall = !adv;

	always_comb begin
		tok[0].vld   = item_valid;
		tok[0].last  = item.last;
		tok[0].found = 1'b0;
		tok[0].kept  = 1'b0;
		tok[0].value = item.value;
	end

	assign cnt[0] = '0;

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		sdfo_cell #(
			.CNT_W(CNT_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.tok    (tok[k]),
			.cnt    (cnt[k]),
			.tok_nxt(tok[k+1]),
			.cnt_nxt(cnt[k+1])
		);
	end

	assign cnt_ext = {{OUT_CNT_W{1'b0}}, cnt[DEPTH]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= tok[DEPTH].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tok[DEPTH].vld) begin
			res_q.value_out      <= tok[DEPTH].value;
			res_q.keep           <= tok[DEPTH].kept;
			res_q.distinct_count <= cnt_ext[OUT_CNT_W-1:0];
			res_q.overflow       <= !tok[DEPTH].found && !tok[DEPTH].kept;
			res_q.last_out       <= tok[DEPTH].last;
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

	a_keep_not_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.keep && result.overflow))
		else $error("A result is flagged both kept and overflow.");

	a_keep_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.keep && DEPTH < 128) |-> (result.distinct_count != 7'd0))
		else $error("A kept value reports an empty store.");

	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |-> item_stall)
		else $error("Input taken while the result register is held.");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.overflow && DEPTH < 128)
			|-> (result.distinct_count == 7'(DEPTH)))
		else $error("Overflow reported while the store was not full.");

endmodule

>>> hw/rtl/sdfo_cell.sv
// One storage cell of the chain: holds one distinct value and passes requests onward.
`timescale 1ns / 1ps
module sdfo_cell
	import sdfo_pkg::*;
#(
	parameter int unsigned CNT_W = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  sdfo_tok_t        tok,
	input  logic [CNT_W-1:0] cnt,
	output sdfo_tok_t        tok_nxt,
	output logic [CNT_W-1:0] cnt_nxt
);

	logic               vld_s1;
	sdfo_tok_t          tok_s1;
	sdfo_tok_t          tok_upd;
	logic [CNT_W-1:0]   cnt_s1;
	logic               occ_q;
	logic signed [31:0] entry_q;
	logic               match;
	logic               grab;

	assign match = occ_q && (entry_q == tok.value);
	assign grab  = tok.vld && !occ_q && !tok.found && !tok.kept;

	always_comb begin
		tok_upd       = tok;
		tok_upd.found = tok.found || match;
		tok_upd.kept  = tok.kept || grab;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			occ_q  <= 1'b0;
		end else if (en) begin
			vld_s1 <= tok.vld;
			if (tok.vld) begin
				if (tok.last) begin
					occ_q <= 1'b0;
				end else if (grab) begin
					occ_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tok_s1 <= tok_upd;
			if (occ_q || grab) begin
				cnt_s1 <= cnt + CNT_W'(1);
			end else begin
				cnt_s1 <= cnt;
			end
			if (grab) begin
				entry_q <= tok.value;
			end
		end
	end

	always_comb begin
		tok_nxt     = tok_s1;
		tok_nxt.vld = vld_s1;
	end

	assign cnt_nxt = cnt_s1;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the order-preserving duplicate removal unit.
`timescale 1ns / 1ps
module tb_top;
	import sdfo_pkg::*;

	localparam int unsigned STORE_DEPTH = 64;

	typedef struct {
		logic signed [31:0] value;
		logic               last;
		bit                 typed;
		logic               keep;
		logic [6:0]         count;
		logic               overflow;
	} dir_row_t;

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_stall;
	sdfo_in_t  item;
	logic      result_valid;
	logic      result_stall;
	sdfo_out_t result;

	logic signed [31:0] held_vals [STORE_DEPTH];
	int                 held_count;
	sdfo_out_t          pending_results [$];
	sdfo_out_t          oldest_exp;
	int                 send_idle_pct;
	int                 recv_stall_pct;
	int                 mismatches;
	int                 requests_sent;
	int                 results_seen;
	int                 kept_total;
	int                 dup_total;
	int                 overflow_total;
	int                 set_total;

	dir_row_t dir_rows [15] = '{
		'{32'sh00000000, 1'b0, 1'b1, 1'b1, 7'd1, 1'b0},
		'{32'sh00000000, 1'b0, 1'b1, 1'b0, 7'd1, 1'b0},
		'{32'sh7fffffff, 1'b0, 1'b1, 1'b1, 7'd2, 1'b0},
		'{32'sh80000000, 1'b0, 1'b1, 1'b1, 7'd3, 1'b0},
		'{32'shffffffff, 1'b0, 1'b1, 1'b1, 7'd4, 1'b0},
		'{32'sh80000000, 1'b0, 1'b1, 1'b0, 7'd4, 1'b0},
		'{32'sh00012345, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0},
		'{32'shfffedcbb, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0},
		'{32'sh00012345, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0},
		'{32'sh00000001, 1'b1, 1'b1, 1'b1, 7'd7, 1'b0},
		'{32'sh00000000, 1'b0, 1'b1, 1'b1, 7'd1, 1'b0},
		'{32'sh00000000, 1'b1, 1'b1, 1'b0, 7'd1, 1'b0},
		'{32'sh00000005, 1'b1, 1'b1, 1'b1, 7'd1, 1'b0},
		'{32'sh55555555, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0},
		'{32'shaaaaaaaa, 1'b1, 1'b0, 1'b0, 7'd0, 1'b0}
	};

	stream_dedup_first_occurrence_unit #(
		.DEPTH(STORE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic sdfo_out_t dedup_step(input sdfo_in_t req);
		sdfo_out_t res;
		bit        hit;
		hit = 1'b0;
		for (int i = 0; i < held_count; i++) begin
			if (held_vals[i] == req.value)
				hit = 1'b1;
		end
		res.value_out = req.value;
		res.keep      = 1'b0;
		res.overflow  = 1'b0;
		res.last_out  = req.last;
		if (hit) begin
			dup_total++;
		end else if (held_count < STORE_DEPTH) begin
			held_vals[held_count] = req.value;
			held_count++;
			res.keep = 1'b1;
			kept_total++;
		end else begin
			res.overflow = 1'b1;
			overflow_total++;
		end
		res.distinct_count = 7'(held_count);
		if (req.last) begin
			held_count = 0;
			set_total++;
		end
		return res;
	endfunction

	task automatic push_item(input logic signed [31:0] v, input logic l, input bit typed,
			input sdfo_out_t typed_res);
		sdfo_in_t  req;
		sdfo_out_t exp;
		req.value = v;
		req.last  = l;
		exp = dedup_step(req);
		if (typed)
			exp = typed_res;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= req;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		pending_results.push_back(exp);
		requests_sent++;
	endtask

	task automatic random_set(input bit force_long);
		int                 kind;
		int                 len;
		logic [31:0]        base;
		logic [31:0]        stride;
		logic [31:0]        off;
		logic signed [31:0] v;
		kind   = $urandom_range(0, 99);
		base   = $urandom;
		stride = $urandom | 32'd1;
		len    = $urandom_range(1, 10);
		if (force_long || kind < 8)
			len = $urandom_range(85, 100);
		for (int i = 0; i < len; i++) begin
			if (force_long || kind < 8) begin
				off = ($urandom_range(0, 4) == 0) ? $urandom_range(0, i) : i;
				v = base + off * stride;
			end else if (kind < 50) begin
				v = base + $urandom_range(0, 5);
			end else if (kind < 70) begin
				v = $urandom;
			end else if (kind < 85) begin
				case ($urandom_range(0, 4))
					0: v = 32'sh80000000;
					1: v = 32'sh7fffffff;
					2: v = 32'sh00000000;
					3: v = 32'shffffffff;
					default: v = 32'sh00000001;
				endcase
			end else begin
				v = 32'sh1 << $urandom_range(0, 31);
				if ($urandom_range(0, 1))
					v = ~v;
			end
			push_item(v, (i == len - 1), 1'b0, '0);
		end
	endtask

	function automatic void check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		result_stall <= arst_n && ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, result);
				mismatches++;
			end else begin
				oldest_exp = pending_results.pop_front();
				check_field("value_out", 32'(oldest_exp.value_out), 32'(result.value_out));
				check_field("keep", 32'(oldest_exp.keep), 32'(result.keep));
				check_field("distinct_count", 32'(oldest_exp.distinct_count),
					32'(result.distinct_count));
				check_field("overflow", 32'(oldest_exp.overflow), 32'(result.overflow));
				check_field("last_out", 32'(oldest_exp.last_out), 32'(result.last_out));
			end
		end
	end

	initial begin
		#2_000_000;
		$display("stream_dedup_first_occurrence_unit verification failed");
		$finish;
	end

	initial begin
		sdfo_out_t typed_res;
		int        phase_end;
		arst_n         <= 1'b0;
		item_valid     <= 1'b0;
		item           <= '0;
		result_stall   <= 1'b0;
		held_count     = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		mismatches     = 0;
		requests_sent  = 0;
		results_seen   = 0;
		kept_total     = 0;
		dup_total      = 0;
		overflow_total = 0;
		set_total      = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			typed_res.value_out      = dir_rows[r].value;
			typed_res.keep           = dir_rows[r].keep;
			typed_res.distinct_count = dir_rows[r].count;
			typed_res.overflow       = dir_rows[r].overflow;
			typed_res.last_out       = dir_rows[r].last;
			push_item(dir_rows[r].value, dir_rows[r].last, dir_rows[r].typed, typed_res);
		end

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
				default: begin send_idle_pct = 21; recv_stall_pct = 21; end
			endcase
			phase_end = requests_sent + 100;
			if (p == 2)
				random_set(1'b1);
			while (requests_sent < phase_end)
				random_set(1'b0);
		end
		item_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (STORE_DEPTH + 10) @(posedge clk);

		$display("Checked %0d results from %0d requests in %0d sets.",
			results_seen, requests_sent, set_total);
		$display("First occurrences %0d, duplicates %0d, overflows with a full store %0d.",
			kept_total, dup_total, overflow_total);
		if (mismatches == 0)
			$display("stream_dedup_first_occurrence_unit verification clean");
		else
			$display("stream_dedup_first_occurrence_unit verification failed");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/sdfo_pkg.sv
hw/rtl/sdfo_cell.sv
hw/rtl/stream_dedup_first_occurrence_unit.sv
tb/tb_top.sv
